### rtl/core/ansi_color_escape_parser_macros.svh
// assertion helpers for the colour escape parser
`ifndef ANSI_COLOR_ESCAPE_PARSER_MACROS_SVH
`define ANSI_COLOR_ESCAPE_PARSER_MACROS_SVH

// same-cycle implication, held off during reset
`define ACP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acp assertion failed");

// next-cycle implication, held off during reset
`define ACP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acp assertion failed");

`endif

### rtl/core/acp_pkg.sv
package acp_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND  = 2'd1;

    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_END   = 8'h6D;
    localparam logic [7:0] BYTE_SEP   = 8'h3B;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    localparam logic EV_PRINT = 1'b0;
    localparam logic EV_BKSP  = 1'b1;

    localparam logic [3:0] FG_WHITE = 4'd15;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_BKSP,
        OP_END,
        OP_SEP,
        OP_DIGIT
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/core/ansi_color_escape_parser.sv
// Colour escape parser: takes one terminal byte per cycle on i_valid/o_stall and gives print
// and backspace events on o_valid/i_stall. A byte's event passes the front classifier and the
// two-entry op queue, then the back executor's output register, before it shows on o_valid;
// sustained rate is one byte per cycle while i_stall is low, and a stalled output backs up
// through the queue to o_stall after two more bytes.
// ESC, '[', digits, ';' and 'm' of a sequence give no event.
// Configuration writes on i_cfg_valid (o_cfg_ready is always high) should be done while idle.
`include "ansi_color_escape_parser_macros.svh"

module ansi_color_escape_parser #(
    parameter int unsigned QUEUE_DEPTH = acp_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_byte_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_event_kind,
    output logic [7:0]                     o_char_code,
    output logic [3:0]                     o_fg_color,
    output logic [3:0]                     o_bg_color,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [acp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_echo_enable;
    logic [3:0]         r_background;
    logic               q_push;
    logic               q_pop;
    acp_pkg::t_op       q_in_op;
    acp_pkg::t_op       q_out_op;
    acp_pkg::t_q_status q_status;
    logic               in_accept;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_enable <= 1'b1;
            r_background  <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == acp_pkg::CFG_ECHO_ENABLE) begin
                r_echo_enable <= i_cfg_data[0];
            end else if (i_cfg_index == acp_pkg::CFG_BACKGROUND) begin
                r_background <= i_cfg_data[3:0];
            end
        end
    end

    acp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_byte_in     (i_byte_in),
        .i_echo_enable (r_echo_enable),
        .i_q_status    (q_status),
        .o_stall       (o_stall),
        .o_push        (q_push),
        .o_op          (q_in_op)
    );

    acp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_op     (q_in_op),
        .i_pop    (q_pop),
        .o_op     (q_out_op),
        .o_status (q_status)
    );

    acp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (q_out_op),
        .i_q_status   (q_status),
        .i_background (r_background),
        .i_stall      (i_stall),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_char_code  (o_char_code),
        .o_fg_color   (o_fg_color),
        .o_bg_color   (o_bg_color)
    );

    `ACP_ASSERT_IMPLY(a_push_not_full, i_clk, i_rst_n, q_push, !q_status.full)
    `ACP_ASSERT_IMPLY(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_status.empty)
    `ACP_ASSERT_IMPLY(a_esc_not_queued, i_clk, i_rst_n, in_accept && (i_byte_in == acp_pkg::BYTE_ESC), !q_push)
    `ACP_ASSERT_IMPLY(a_bksp_code, i_clk, i_rst_n, o_valid && (o_event_kind == acp_pkg::EV_BKSP), o_char_code == acp_pkg::BYTE_BS)
    `ACP_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push && !q_pop, !q_status.empty)

endmodule

### rtl/core/acp_front.sv
module acp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte_in,
    input  logic           i_echo_enable,
    input  acp_pkg::t_q_status i_q_status,
    output logic           o_stall,
    output logic           o_push,
    output acp_pkg::t_op   o_op
);

    logic r_in_escape;
    logic n_in_escape;
    logic accept;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    always_comb begin
        n_in_escape = r_in_escape;
        o_push      = 1'b0;
        o_op.kind   = acp_pkg::OP_PRINT;
        o_op.data   = i_byte_in;
        if (accept) begin
            priority if (i_byte_in == acp_pkg::BYTE_ESC) begin
                n_in_escape = 1'b1;
            end else if (i_byte_in == acp_pkg::BYTE_BS) begin
                o_push    = 1'b1;
                o_op.kind = acp_pkg::OP_BKSP;
            end else if (r_in_escape) begin
                priority if (i_byte_in == acp_pkg::BYTE_END) begin
                    o_push      = 1'b1;
                    o_op.kind   = acp_pkg::OP_END;
                    n_in_escape = 1'b0;
                end else if (i_byte_in == acp_pkg::BYTE_SEP) begin
                    o_push    = 1'b1;
                    o_op.kind = acp_pkg::OP_SEP;
                end else if (i_byte_in >= acp_pkg::BYTE_ZERO &&
                             i_byte_in <= acp_pkg::BYTE_NINE) begin
                    // ascii digits carry their value in the low nibble
                    o_push    = 1'b1;
                    o_op.kind = acp_pkg::OP_DIGIT;
                    o_op.data = {4'd0, i_byte_in[3:0]};
                end else begin
                    o_push = 1'b0;
                end
            end else if (i_echo_enable) begin
                o_push    = 1'b1;
                o_op.kind = acp_pkg::OP_PRINT;
            end else begin
                o_push = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_escape <= 1'b0;
        end else begin
            r_in_escape <= n_in_escape;
        end
    end

endmodule

### rtl/core/acp_queue.sv
module acp_queue #(
    parameter int unsigned DEPTH = acp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  acp_pkg::t_op       i_op,
    input  logic               i_pop,
    output acp_pkg::t_op       o_op,
    output acp_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    acp_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_op           = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/acp_back.sv
module acp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acp_pkg::t_op       i_op,
    input  acp_pkg::t_q_status i_q_status,
    input  logic [3:0]         i_background,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output logic               o_event_kind,
    output logic [7:0]         o_char_code,
    output logic [3:0]         o_fg_color,
    output logic [3:0]         o_bg_color
);

    logic [1:0] r_field_pos;
    logic [7:0] r_mode;
    logic [7:0] r_color;
    logic [3:0] r_fg;
    logic       r_out_valid;
    logic       r_out_kind;
    logic [7:0] r_out_char;
    logic [3:0] r_out_fg;
    logic [3:0] r_out_bg;

    logic       needs_out;
    logic       slot_free;

    // decimal accumulate, clamped at 255
    function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, d};
        add_digit = (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    // 30..37 map to vga order, which is the bit-reversed index
    function automatic logic [3:0] seq_colour(input logic [7:0] mode, input logic [7:0] colour,
                                              input logic [3:0] fg);
        logic       known;
        logic [2:0] idx;
        logic [2:0] vga;
        known = (colour >= 8'd30) && (colour <= 8'd37);
        idx   = colour[2:0] - 3'd6;
        vga   = {idx[0], idx[1], idx[2]};
        if (mode == 8'd0) begin
            seq_colour = known ? {1'b0, vga} : acp_pkg::FG_WHITE;
        end else if (mode == 8'd1) begin
            seq_colour = known ? {1'b1, vga} : acp_pkg::FG_WHITE;
        end else begin
            seq_colour = fg;
        end
    endfunction

    assign needs_out = (i_op.kind == acp_pkg::OP_PRINT) || (i_op.kind == acp_pkg::OP_BKSP);
    assign slot_free = !r_out_valid || !i_stall;
    assign o_pop     = !i_q_status.empty && (!needs_out || slot_free);

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_char_code  = r_out_char;
    assign o_fg_color   = r_out_fg;
    assign o_bg_color   = r_out_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_pos <= 2'd0;
            r_mode      <= 8'd0;
            r_color     <= 8'd0;
            r_fg        <= acp_pkg::FG_WHITE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && needs_out) begin
                r_out_valid <= 1'b1;
            end else if (slot_free) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_op.kind)
                    acp_pkg::OP_PRINT: begin
                        r_out_kind  <= acp_pkg::EV_PRINT;
                        r_out_char  <= i_op.data;
                        r_out_fg    <= r_fg;
                        r_out_bg    <= i_background;
                    end
                    acp_pkg::OP_BKSP: begin
                        r_out_kind  <= acp_pkg::EV_BKSP;
                        r_out_char  <= i_op.data;
                        r_out_fg    <= r_fg;
                        r_out_bg    <= i_background;
                    end
                    acp_pkg::OP_END: begin
                        r_fg        <= seq_colour(r_mode, r_color, r_fg);
                        r_field_pos <= 2'd0;
                        r_mode      <= 8'd0;
                        r_color     <= 8'd0;
                    end
                    acp_pkg::OP_SEP: begin
                        if (r_field_pos < 2'd2) begin
                            r_field_pos <= r_field_pos + 2'd1;
                        end
                    end
                    acp_pkg::OP_DIGIT: begin
                        if (r_field_pos == 2'd0) begin
                            r_mode <= add_digit(r_mode, i_op.data[3:0]);
                        end else if (r_field_pos == 2'd1) begin
                            r_color <= add_digit(r_color, i_op.data[3:0]);
                        end
                    end
                    default: begin
                        r_field_pos <= r_field_pos;
                    end
                endcase
            end
        end
    end

endmodule
